FILE: rtl/x86alu_pkg.sv
// ----------------------------------------------------------------------------
// x86alu_pkg: shared types, codes and flag helpers
// Command codes, request and result structs, flag bit positions.
// ----------------------------------------------------------------------------
`default_nettype none
package x86alu_pkg;
    typedef enum logic [4:0] {
        CMD_ADD = 5'd0, CMD_OR = 5'd1, CMD_ADC = 5'd2, CMD_SBB = 5'd3,
        CMD_AND = 5'd4, CMD_SUB = 5'd5, CMD_XOR = 5'd6, CMD_CMP = 5'd7,
        CMD_INC = 5'd8, CMD_DEC = 5'd9, CMD_NEG = 5'd10, CMD_NOT = 5'd11,
        CMD_ROL = 5'd12, CMD_ROR = 5'd13, CMD_RCL = 5'd14, CMD_RCR = 5'd15,
        CMD_SHL = 5'd16, CMD_SHR = 5'd17, CMD_SAR = 5'd18, CMD_MUL = 5'd19,
        CMD_IMUL = 5'd20, CMD_DIV = 5'd21, CMD_IDIV = 5'd22, CMD_DAA = 5'd23,
        CMD_DAS = 5'd24, CMD_AAA = 5'd25, CMD_AAS = 5'd26, CMD_AAM = 5'd27,
        CMD_AAD = 5'd28
    } t_cmd;

    localparam int F_CF = 0;
    localparam int F_PF = 2;
    localparam int F_AF = 4;
    localparam int F_ZF = 6;
    localparam int F_SF = 7;
    localparam int F_OF = 11;

    typedef struct packed {
        logic [4:0]  command;
        logic        word_size;
        logic [15:0] operand_a;
        logic [15:0] operand_b;
        logic [15:0] operand_high;
        logic [7:0]  shift_count;
        logic [15:0] flags_in;
    } t_req;

    typedef struct packed {
        logic [15:0] result_low;
        logic [15:0] result_high;
        logic [15:0] flags_out;
        logic        divide_error;
        logic        write_back;
    } t_res;

    // Control from sequencer to the shared divider datapath
    typedef struct packed {
        logic load;
        logic step;
    } t_dp_ctl;

    function automatic logic [15:0] put_pzs(input logic [15:0] f, input logic [15:0] v,
                                            input logic w);
        logic [15:0] r;
        r = f;
        r[F_PF] = ~^v[7:0];
        r[F_ZF] = w ? (v == 16'h0) : (v[7:0] == 8'h0);
        r[F_SF] = w ? v[15] : v[7];
        return r;
    endfunction
endpackage
`default_nettype wire

FILE: rtl/x86alu_div.sv
// ----------------------------------------------------------------------------
// x86alu_div: shared restoring divider
// Unsigned 32 by 16 division, one quotient bit per step.
// ----------------------------------------------------------------------------
`default_nettype none
module x86alu_div (
    input  wire logic                i_clk,
    input  wire x86alu_pkg::t_dp_ctl i_ctl,
    input  wire logic [31:0]         i_num,
    input  wire logic [15:0]         i_den,
    output logic [31:0]              o_quo,
    output logic [16:0]              o_rem
);
    import x86alu_pkg::*;
    logic [31:0] r_q;
    logic [16:0] r_r;
    logic [15:0] r_d;
    logic [17:0] w_try;
    logic [16:0] w_sh;

    assign w_sh  = {r_r[15:0], r_q[31]};
    assign w_try = {1'b0, w_sh} - {2'b00, r_d};

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_q <= i_num;
            r_r <= '0;
            r_d <= i_den;
        end else if (i_ctl.step) begin
            if (!w_try[17]) begin
                r_r <= w_try[16:0];
                r_q <= {r_q[30:0], 1'b1};
            end else begin
                r_r <= w_sh;
                r_q <= {r_q[30:0], 1'b0};
            end
        end
    end
    assign o_quo = r_q;
    assign o_rem = r_r;
endmodule
`default_nettype wire

FILE: rtl/x86_alu_with_flags_unit.sv
// ----------------------------------------------------------------------------
// x86_alu_with_flags_unit: 16-bit x86 ALU with flag rules
// Sequenced unit: one-step ops, shift/rotate per count, divide per bit.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake          | Payload
// request | in        | i_start, o_busy    | i_req (t_req)
// result  | out       | o_done strobe      | o_res (t_res)
//
// Sequence: ALU, logic, multiply and decimal commands finish from S_FIN; shifts
// take one step per count in S_SHIFT; div/idiv/aam take 32 divider steps in S_DIV.
// The shared restoring divider and the one-bit shift step do the work of S_DIV and S_SHIFT.
// Reset is synchronous, active low, and returns the sequencer to idle.
// The result strobe lasts one cycle; the receiver cannot stall.
`default_nettype none
module x86_alu_with_flags_unit (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire x86alu_pkg::t_req  i_req,
    output logic                   o_busy,
    output logic                   o_done,
    output x86alu_pkg::t_res       o_res
);
    import x86alu_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001, S_SHIFT = 4'b0010, S_DIV = 4'b0100, S_FIN = 4'b1000
    } t_state;

    t_state      r_state, n_state;
    t_req        r_req;
    logic [5:0]  r_cnt, n_cnt;
    logic [15:0] r_d;
    logic        r_c, r_ov;
    logic        r_done;
    t_res        r_res, n_res;
    t_dp_ctl     w_ctl;
    logic [31:0] w_quo;
    logic [16:0] w_rem;

    // operand views of the latched request
    logic        w;
    logic [15:0] m, a, b, f;
    logic [7:0]  al, ah;
    logic [4:0]  cmd;
    assign cmd = r_req.command;
    assign w  = r_req.word_size;
    assign m  = w ? 16'hffff : 16'h00ff;
    assign a  = r_req.operand_a & m;
    assign b  = r_req.operand_b & m;
    assign f  = r_req.flags_in;
    assign al = r_req.operand_a[7:0];
    assign ah = r_req.operand_high[7:0];

    // divide set-up: magnitudes for idiv, plain for div and aam
    logic        is_aam, nneg, dneg;
    logic [31:0] num, nmag;
    logic [15:0] dmag;
    assign is_aam = (cmd == CMD_AAM);
    assign num  = is_aam ? {24'h0, al} :
                  w ? {r_req.operand_high, a} : {16'h0, ah, al};
    assign nneg = (cmd == CMD_IDIV) && (w ? num[31] : num[15]);
    assign dneg = (cmd == CMD_IDIV) && (w ? b[15] : b[7]);
    assign nmag = nneg ? (w ? 32'h0 - num : {16'h0, 16'h0 - num[15:0]}) : num;
    assign dmag = is_aam ? {8'h0, r_req.operand_b[7:0]} : (dneg ? (m + 16'd1 - b) : b);

    x86alu_div u_div (
        .i_clk (i_clk), .i_ctl (w_ctl), .i_num (nmag), .i_den (dmag),
        .o_quo (w_quo), .o_rem (w_rem)
    );

    // one shift step
    logic [15:0] sb, sd;
    logic        sc;
    assign sb = w ? 16'h8000 : 16'h0080;
    always_comb begin
        sd = r_d;
        sc = r_c;
        case (cmd)
            CMD_ROL: begin sc = |(r_d & sb); sd = ((r_d << 1) | {15'h0, sc}) & m; end
            CMD_ROR: begin sc = r_d[0]; sd = (r_d >> 1) | (sc ? sb : 16'h0); end
            CMD_RCL: begin sc = |(r_d & sb); sd = ((r_d << 1) | {15'h0, r_c}) & m; end
            CMD_RCR: begin sc = r_d[0]; sd = (r_d >> 1) | (r_c ? sb : 16'h0); end
            CMD_SHL: begin sc = |(r_d & sb); sd = (r_d << 1) & m; end
            CMD_SHR: begin sc = r_d[0]; sd = r_d >> 1; end
            default: begin sc = r_d[0]; sd = (r_d >> 1) | (r_d & sb); end
        endcase
    end

    // combinational result for the simple commands
    function automatic t_res one_cycle(input t_req q);
        t_res        o;
        logic        ww, cf, sub, c;
        logic [15:0] mm, aa, bb, ff, sgn, r16, ext, lo, hi;
        logic [16:0] x, y, r;
        logic [7:0]  xa, t8;
        logic [8:0]  t;
        logic [31:0] p;
        logic [15:0] sxa, sxb;
        ww  = q.word_size;
        mm  = ww ? 16'hffff : 16'h00ff;
        sgn = ww ? 16'h8000 : 16'h0080;
        aa  = q.operand_a & mm;
        bb  = q.operand_b & mm;
        ff  = q.flags_in;
        cf  = ff[F_CF];
        o   = '0;
        o.write_back = 1'b1;
        o.flags_out  = ff;
        sub = 1'b0; c = 1'b0; x = {1'b0, aa}; y = {1'b0, bb};
        lo = '0; hi = '0; xa = '0; t = '0; t8 = '0; p = '0; ext = '0;
        sxa = '0; sxb = '0; r = '0; r16 = '0;
        case (q.command)
            CMD_ADD, CMD_ADC, CMD_SBB, CMD_SUB, CMD_CMP, CMD_INC, CMD_DEC,
            CMD_NEG: begin
                sub = (q.command == CMD_SBB) || (q.command == CMD_SUB) ||
                      (q.command == CMD_CMP) || (q.command == CMD_DEC) ||
                      (q.command == CMD_NEG);
                c = ((q.command == CMD_ADC) || (q.command == CMD_SBB)) ? cf : 1'b0;
                if (q.command == CMD_INC || q.command == CMD_DEC) y = 17'd1;
                if (q.command == CMD_NEG) begin x = '0; y = {1'b0, aa}; end
                r = sub ? x - y - {16'h0, c} : x + y + {16'h0, c};
                r16 = r[15:0] & mm;
                o.result_low = r16;
                o.flags_out = put_pzs(ff, r16, ww);
                o.flags_out[F_AF] = x[4] ^ y[4] ^ r[4];
                o.flags_out[F_CF] = ww ? r[16] : r[8];
                o.flags_out[F_OF] = sub ? |((x[15:0] ^ y[15:0]) & (x[15:0] ^ r[15:0]) & sgn)
                                        : |((x[15:0] ^ r[15:0]) & (y[15:0] ^ r[15:0]) & sgn);
                if (q.command == CMD_INC || q.command == CMD_DEC) o.flags_out[F_CF] = cf;
                if (q.command == CMD_CMP) o.write_back = 1'b0;
            end
            CMD_OR, CMD_AND, CMD_XOR: begin
                lo = (q.command == CMD_OR) ? (aa | bb) :
                     (q.command == CMD_AND) ? (aa & bb) : (aa ^ bb);
                o.result_low = lo;
                o.flags_out = put_pzs(ff, lo, ww);
                o.flags_out[F_CF] = 1'b0;
                o.flags_out[F_AF] = 1'b0;
                o.flags_out[F_OF] = 1'b0;
            end
            CMD_NOT: o.result_low = ~aa & mm;
            CMD_MUL, CMD_IMUL: begin
                if (q.command == CMD_MUL) p = aa * bb;
                else begin
                    sxa = ww ? aa : {{8{aa[7]}}, aa[7:0]};
                    sxb = ww ? bb : {{8{bb[7]}}, bb[7:0]};
                    p = $signed(sxa) * $signed(sxb);
                end
                lo = p[15:0] & mm;
                hi = (ww ? p[31:16] : {8'h0, p[15:8]}) & mm;
                o.result_low = lo;
                o.result_high = hi;
                o.flags_out[F_SF] = |(aa & sgn);
                o.flags_out[F_PF] = ~^aa[7:0];
                o.flags_out[F_ZF] = ww ? ((lo | hi) == 16'h0) : (lo == 16'h0);
                ext = (q.command == CMD_IMUL && |(lo & sgn)) ? mm : 16'h0;
                o.flags_out[F_CF] = hi != ext;
                o.flags_out[F_OF] = hi != ext;
            end
            CMD_DAA, CMD_DAS: begin
                xa = q.operand_a[7:0];
                if (ff[F_AF] || xa[3:0] > 4'd9) begin
                    t = (q.command == CMD_DAA) ? {1'b0, xa} + 9'd6 : {1'b0, xa} - 9'd6;
                    xa = t[7:0];
                    ff[F_AF] = 1'b1;
                    if (t[8]) ff[F_CF] = 1'b1;
                end
                if (xa > 8'h9f) ff[F_CF] = 1'b1;
                if (ff[F_CF]) xa = (q.command == CMD_DAA) ? xa + 8'h60 : xa - 8'h60;
                o.result_low = {8'h0, xa};
                o.flags_out = put_pzs(ff, {8'h0, xa}, 1'b0);
            end
            CMD_AAA, CMD_AAS: begin
                xa = q.operand_a[7:0];
                t8 = q.operand_high[7:0];
                if (ff[F_AF] || xa[3:0] > 4'd9) begin
                    xa = (q.command == CMD_AAA) ? xa + 8'd6 : xa - 8'd6;
                    t8 = (q.command == CMD_AAA) ? t8 + 8'd1 : t8 - 8'd1;
                    ff[F_CF] = 1'b1; ff[F_AF] = 1'b1;
                end else begin
                    ff[F_CF] = 1'b0; ff[F_AF] = 1'b0;
                end
                o.result_low = {t8, 4'h0, xa[3:0]};
                o.flags_out = ff;
            end
            CMD_AAD: begin
                t8 = q.operand_high[7:0] * q.operand_b[7:0];
                xa = q.operand_a[7:0] + t8;
                o.result_low = {8'h0, xa};
                o.flags_out = put_pzs(ff, {8'h0, xa}, 1'b0);
            end
            default: o.write_back = 1'b0;
        endcase
        return o;
    endfunction

    // finish of the divide commands
    logic [15:0] qm, rm;
    logic        qneg, ovf;
    t_res        div_res;
    assign qm   = w_quo[15:0];
    assign rm   = w_rem[15:0];
    assign qneg = nneg ^ dneg;
    always_comb begin
        div_res = '0;
        div_res.flags_out = f;
        ovf = 1'b0;
        if (is_aam) begin
            div_res.result_low = {w_quo[7:0], w_rem[7:0]};
            div_res.flags_out  = put_pzs(f, {8'h0, w_rem[7:0]}, 1'b0);
            div_res.write_back = 1'b1;
        end else begin
            if (cmd == CMD_DIV) ovf = (w_quo > {16'h0, m});
            else ovf = (w_quo > {16'h0, qneg ? sb : sb - 16'd1});
            div_res.result_low  = qneg ? (16'h0 - qm) & m : qm;
            div_res.result_high = nneg ? (16'h0 - rm) & m : rm;
            div_res.write_back  = 1'b1;
        end
        if (dmag == 16'h0 || ovf) begin
            div_res = '0;
            div_res.flags_out = f;
            div_res.divide_error = 1'b1;
        end
    end

    // shift finish
    t_res sh_res;
    always_comb begin
        sh_res = '0;
        sh_res.write_back = 1'b1;
        sh_res.result_low = r_d;
        sh_res.flags_out  = f;
        if (r_req.shift_count != 8'h0) begin
            sh_res.flags_out[F_CF] = r_c;
            sh_res.flags_out[F_OF] = r_ov;
            if (cmd == CMD_SHL || cmd == CMD_SHR || cmd == CMD_SAR)
                sh_res.flags_out = put_pzs(sh_res.flags_out, r_d, w);
            if (cmd == CMD_SHR || cmd == CMD_SAR) sh_res.flags_out[F_AF] = 1'b1;
        end
    end

    logic is_shift, is_div;
    assign is_shift = (cmd >= CMD_ROL) && (cmd <= CMD_SAR);
    assign is_div   = (cmd == CMD_DIV) || (cmd == CMD_IDIV) || is_aam;

    // sequencer
    logic [7:0] r_left;
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_res   = r_res;
        w_ctl   = '0;
        unique case (r_state)
            S_IDLE: ;
            S_FIN: begin
                // latched request: pick path
                if (is_shift) n_state = S_SHIFT;
                else if (is_div) begin
                    w_ctl.load = 1'b1;
                    n_cnt = 6'd0;
                    n_state = S_DIV;
                end else begin
                    n_res = one_cycle(r_req);
                    n_state = S_IDLE;
                end
            end
            S_SHIFT: begin
                if (r_left == 8'h0) begin
                    n_res = sh_res;
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                if (r_cnt == 6'd32) begin
                    n_res = div_res;
                    n_state = S_IDLE;
                end else begin
                    w_ctl.step = 1'b1;
                    n_cnt = r_cnt + 6'd1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= (r_state != S_IDLE) && (n_state == S_IDLE);
            r_cnt  <= n_cnt;
            if (r_state == S_IDLE) begin
                if (i_start) r_state <= S_FIN;
            end else begin
                r_state <= n_state;
            end
        end
    end

    // payload: request latch, shift engine, result register
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (r_state == S_IDLE && i_start) begin
            r_req  <= i_req;
            r_d    <= i_req.operand_a & (i_req.word_size ? 16'hffff : 16'h00ff);
            r_c    <= i_req.flags_in[F_CF];
            r_ov   <= 1'b0;
            r_left <= i_req.shift_count;
        end else if (r_state == S_SHIFT && r_left != 8'h0) begin
            r_d    <= sd;
            r_c    <= sc;
            r_ov   <= |((sd ^ r_d) & sb);
            r_left <= r_left - 8'd1;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_res  = r_res;

`ifndef SYNTHESIS
    // strobe only after leaving work
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(o_busy)) else $error("result strobe without work");
    // no back-to-back strobes
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("double result strobe");
    // divider never exceeds its bit count
    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 6'd32) else $error("divider step count overrun");
`endif
endmodule
`default_nettype wire
